### src/vits_pkg.sv
// Shared types and constants of the vector index top-k search block.
`timescale 1ns / 1ps
package vits_pkg;

  // Field widths fixed by the interface.
  localparam int DIM_CFG_W = 9;
  localparam logic [DIM_CFG_W-1:0] DIM_CFG_RESET = 9'd256;
  localparam int KEY_W = 64;
  localparam int VAL_W = 16;
  localparam int SCORE_W = 32;
  localparam int ROW_OUT_W = 10;
  localparam int WANT_W = 5;

  // Operation codes of an input beat.
  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_REMOVE = 2'd1,
    OP_SEARCH = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  // Status codes of a result beat.
  typedef enum logic [2:0] {
    RES_HIT       = 3'd0,
    RES_NO_HITS   = 3'd1,
    RES_ADDED     = 3'd2,
    RES_FULL      = 3'd3,
    RES_REMOVED   = 3'd4,
    RES_NOT_FOUND = 3'd5
  } res_t;

  // Controller states.
  typedef enum logic [4:0] {
    S_IDLE,
    S_FIND_RD,
    S_FIND_CHK,
    S_FIND_MISS,
    S_POP,
    S_KEY_WR,
    S_WR_RUN,
    S_WR_TAIL,
    S_RM,
    S_SRCH_BEGIN,
    S_SC_RD,
    S_SC_CHK,
    S_SC_MAC,
    S_SC_DRAIN,
    S_SC_INS,
    S_SC_FIN,
    S_EM_RD,
    S_EM_OUT,
    S_RM_MISS,
    S_ADD_FULL,
    S_NOHIT,
    S_RM_DONE,
    S_ADD_DONE
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic elem_wr;
    logic op_start;
    logic row_inc;
    logic tgt_row;
    logic pop;
    logic tgt_pop;
    logic alloc;
    logic key_wr;
    logic key_valid;
    logic push;
    logic idx_clr;
    logic wr_step;
    logic mac_clr;
    logic mac_step;
    logic insert;
    logic j_clr;
    logic krd_best;
    logic emit;
    logic emit_hit;
    res_t resp_code;
    logic resp_key;
    logic resp_row;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic op_add;
    logic row_end;
    logic key_hit;
    logic row_live;
    logic free_avail;
    logic new_avail;
    logic idx_last;
    logic mac_last;
    logic pipe_busy;
    logic k_zero;
    logic n_zero;
    logic em_last;
    logic out_free;
  } sts_t;

endpackage

### src/vits_ram.sv
// Generic simple dual-port RAM with registered read data.
`timescale 1ns / 1ps
module vits_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // One write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

### src/vits_ctrl.sv
// Controller state machine of the vector index top-k search block.
`timescale 1ns / 1ps
module vits_ctrl import vits_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] in_op,
  input  logic       in_last,
  input  sts_t       sts,
  output cmd_t       cmd
);

  state_t state_r, state_nxt;
  op_t    op_in;

  assign op_in = op_t'(in_op);
  assign in_ready = (state_r == S_IDLE);

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          case (op_in)
            OP_REMOVE: state_nxt = S_FIND_RD;
            OP_ADD:    state_nxt = in_last ? S_FIND_RD : S_IDLE;
            OP_SEARCH: state_nxt = in_last ? S_SRCH_BEGIN : S_IDLE;
            default:   state_nxt = S_IDLE;
          endcase
        end
      end
      S_FIND_RD:  state_nxt = sts.row_end ? S_FIND_MISS : S_FIND_CHK;
      S_FIND_CHK: begin
        if (sts.key_hit) begin
          state_nxt = sts.op_add ? S_WR_RUN : S_RM;
        end else begin
          state_nxt = S_FIND_RD;
        end
      end
      S_FIND_MISS: begin
        if (!sts.op_add) begin
          state_nxt = S_RM_MISS;
        end else if (sts.free_avail) begin
          state_nxt = S_POP;
        end else if (sts.new_avail) begin
          state_nxt = S_KEY_WR;
        end else begin
          state_nxt = S_ADD_FULL;
        end
      end
      S_POP:        state_nxt = S_KEY_WR;
      S_KEY_WR:     state_nxt = S_WR_RUN;
      S_WR_RUN:     state_nxt = sts.idx_last ? S_WR_TAIL : S_WR_RUN;
      S_WR_TAIL:    state_nxt = S_ADD_DONE;
      S_RM:         state_nxt = S_RM_DONE;
      S_SRCH_BEGIN: state_nxt = sts.k_zero ? S_NOHIT : S_SC_RD;
      S_SC_RD:      state_nxt = sts.row_end ? S_SC_FIN : S_SC_CHK;
      S_SC_CHK:     state_nxt = sts.row_live ? S_SC_MAC : S_SC_RD;
      S_SC_MAC:     state_nxt = sts.mac_last ? S_SC_DRAIN : S_SC_MAC;
      S_SC_DRAIN:   state_nxt = sts.pipe_busy ? S_SC_DRAIN : S_SC_INS;
      S_SC_INS:     state_nxt = S_SC_RD;
      S_SC_FIN:     state_nxt = sts.n_zero ? S_NOHIT : S_EM_RD;
      S_EM_RD:      state_nxt = S_EM_OUT;
      S_EM_OUT: begin
        if (sts.out_free) begin
          state_nxt = sts.em_last ? S_IDLE : S_EM_RD;
        end
      end
      S_RM_MISS, S_ADD_FULL, S_NOHIT, S_RM_DONE, S_ADD_DONE: begin
        if (sts.out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Commands for the datapath.
  always_comb begin
    cmd = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.elem_wr  = (op_in == OP_ADD) || (op_in == OP_SEARCH);
          cmd.op_start = (op_in == OP_REMOVE) ||
                         (((op_in == OP_ADD) || (op_in == OP_SEARCH)) && in_last);
        end
      end
      S_FIND_CHK: begin
        if (sts.key_hit) begin
          cmd.tgt_row = 1'b1;
          cmd.idx_clr = 1'b1;
        end else begin
          cmd.row_inc = 1'b1;
        end
      end
      S_FIND_MISS: begin
        cmd.pop   = sts.op_add && sts.free_avail;
        cmd.alloc = sts.op_add && !sts.free_avail && sts.new_avail;
      end
      S_POP: cmd.tgt_pop = 1'b1;
      S_KEY_WR: begin
        cmd.key_wr    = 1'b1;
        cmd.key_valid = 1'b1;
        cmd.idx_clr   = 1'b1;
      end
      S_WR_RUN: cmd.wr_step = 1'b1;
      S_RM: begin
        cmd.key_wr = 1'b1;
        cmd.push   = 1'b1;
      end
      S_SC_CHK: begin
        if (sts.row_live) begin
          cmd.mac_clr = 1'b1;
          cmd.idx_clr = 1'b1;
        end else begin
          cmd.row_inc = 1'b1;
        end
      end
      S_SC_MAC: cmd.mac_step = 1'b1;
      S_SC_INS: begin
        cmd.insert  = 1'b1;
        cmd.row_inc = 1'b1;
      end
      S_SC_FIN: cmd.j_clr = 1'b1;
      S_EM_RD:  cmd.krd_best = 1'b1;
      S_EM_OUT: begin
        cmd.krd_best = 1'b1;
        cmd.emit     = sts.out_free;
        cmd.emit_hit = 1'b1;
      end
      S_RM_MISS: begin
        cmd.emit      = sts.out_free;
        cmd.resp_code = RES_NOT_FOUND;
        cmd.resp_key  = 1'b1;
      end
      S_ADD_FULL: begin
        cmd.emit      = sts.out_free;
        cmd.resp_code = RES_FULL;
        cmd.resp_key  = 1'b1;
      end
      S_NOHIT: begin
        cmd.emit      = sts.out_free;
        cmd.resp_code = RES_NO_HITS;
      end
      S_RM_DONE: begin
        cmd.emit      = sts.out_free;
        cmd.resp_code = RES_REMOVED;
        cmd.resp_key  = 1'b1;
        cmd.resp_row  = 1'b1;
      end
      S_ADD_DONE: begin
        cmd.emit      = sts.out_free;
        cmd.resp_code = RES_ADDED;
        cmd.resp_key  = 1'b1;
        cmd.resp_row  = 1'b1;
      end
      default: cmd = '0;
    endcase
  end

endmodule

### src/vits_dp.sv
// Datapath of the vector index top-k search block: memories, counters, MAC and top-k list.
`timescale 1ns / 1ps
module vits_dp import vits_pkg::*; #(
  parameter int ROW_COUNT = 1024,
  parameter int DIM_MAX = 256,
  parameter int TOP_MAX = 16
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_wr_en,
  input  logic [DIM_CFG_W-1:0]       cfg_wr_data,
  input  logic [1:0]                 in_op,
  input  logic [KEY_W-1:0]           in_key,
  input  logic signed [VAL_W-1:0]    in_value,
  input  logic                       in_last,
  input  logic [WANT_W-1:0]          in_want_count,
  input  cmd_t                       cmd,
  output sts_t                       sts,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [2:0]                 out_status,
  output logic [KEY_W-1:0]           out_hit_key,
  output logic signed [SCORE_W-1:0]  out_score,
  output logic [ROW_OUT_W-1:0]       out_row,
  output logic                       out_final_res
);

  localparam int RW = $clog2(ROW_COUNT);
  localparam int UW = $clog2(ROW_COUNT + 1);
  localparam int IW = (DIM_MAX > 1) ? $clog2(DIM_MAX) : 1;
  localparam int CW = $clog2(DIM_MAX + 1);
  localparam int TW = $clog2(TOP_MAX + 1);
  localparam int JW = (TOP_MAX > 1) ? $clog2(TOP_MAX) : 1;
  localparam int ACC_W = SCORE_W + CW;
  localparam int VDEPTH = ROW_COUNT << IW;

  // Configuration and operation registers.
  logic [DIM_CFG_W-1:0]      cfg_dim_r;
  logic [CW-1:0]             dim;
  logic [CW-1:0]             cnt_r, qlen_r, idx_r;
  logic [KEY_W-1:0]          key_r;
  op_t                       op_r;
  logic [TW-1:0]             k_r, n_r, k_in;
  logic [UW-1:0]             row_r, used_r, fc_r;
  logic [RW-1:0]             tgt_r;
  logic                      elem_take;

  // Pipelines for row writing and scoring.
  logic                      wv_r, v1_r, v2_r;
  logic [CW-1:0]             wi_r, i1_r;
  logic signed [VAL_W-1:0]   qmask;
  logic signed [SCORE_W-1:0] prod_r;
  logic signed [ACC_W-1:0]   acc_r;
  logic signed [SCORE_W-1:0] sat_s;

  // Top-k list.
  logic signed [SCORE_W-1:0] best_s [TOP_MAX];
  logic [RW-1:0]             best_r [TOP_MAX];
  logic signed [SCORE_W-1:0] up_s [TOP_MAX];
  logic [RW-1:0]             up_r [TOP_MAX];
  logic [TOP_MAX-1:0]        ge;
  logic [TOP_MAX:0]          gx;
  logic [JW-1:0]             j_r;

  // Memory ports.
  logic [VAL_W-1:0]          qdout, vdout, vwdata;
  logic [KEY_W:0]            kdout;
  logic [RW-1:0]             sdout, kraddr;

  // Output register.
  logic                      out_valid_r;
  res_t                      out_status_r;
  logic [KEY_W-1:0]          out_key_r;
  logic signed [SCORE_W-1:0] out_score_r;
  logic [RW-1:0]             out_row_r;
  logic                      out_final_r;
  logic                      fire;

  // Clamp the configured dimension to the supported range.
  always_comb begin
    if (cfg_dim_r == '0) begin
      dim = CW'(1);
    end else if (32'(cfg_dim_r) > DIM_MAX) begin
      dim = CW'(DIM_MAX);
    end else begin
      dim = CW'(cfg_dim_r);
    end
  end

  assign elem_take = cmd.elem_wr && (cnt_r < dim);
  assign k_in = (32'(in_want_count) > TOP_MAX) ? TW'(TOP_MAX) : TW'(in_want_count);

  // Configuration, element collection and operation registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_dim_r <= DIM_CFG_RESET;
      cnt_r     <= '0;
      used_r    <= '0;
      fc_r      <= '0;
      op_r      <= OP_NONE;
    end else begin
      if (cfg_wr_en) begin
        cfg_dim_r <= cfg_wr_data;
      end
      if (cmd.elem_wr && in_last) begin
        cnt_r <= '0;
      end else if (elem_take) begin
        cnt_r <= cnt_r + CW'(1);
      end
      if (cmd.op_start) begin
        op_r <= op_t'(in_op);
      end
      if (cmd.alloc) begin
        used_r <= used_r + UW'(1);
      end
      if (cmd.pop) begin
        fc_r <= fc_r - UW'(1);
      end else if (cmd.push && (32'(fc_r) < ROW_COUNT)) begin
        fc_r <= fc_r + UW'(1);
      end
    end
  end

  // Operation payload and scan counters.
  always_ff @(posedge clk) begin
    if (cmd.op_start) begin
      key_r  <= in_key;
      k_r    <= k_in;
      qlen_r <= cnt_r + CW'(elem_take);
      row_r  <= '0;
      n_r    <= '0;
    end else begin
      if (cmd.row_inc) begin
        row_r <= row_r + UW'(1);
      end
      if (cmd.insert && (n_r < k_r)) begin
        n_r <= n_r + TW'(1);
      end
    end
    if (cmd.tgt_row) begin
      tgt_r <= row_r[RW-1:0];
    end else if (cmd.tgt_pop) begin
      tgt_r <= sdout;
    end else if (cmd.alloc) begin
      tgt_r <= used_r[RW-1:0];
    end
    if (cmd.idx_clr) begin
      idx_r <= '0;
    end else if (cmd.wr_step || cmd.mac_step) begin
      idx_r <= idx_r + CW'(1);
    end
    if (cmd.j_clr) begin
      j_r <= '0;
    end else if (cmd.emit && cmd.emit_hit) begin
      j_r <= j_r + JW'(1);
    end
  end

  // Pipeline valid flags.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wv_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      wv_r <= cmd.wr_step;
      v1_r <= cmd.mac_step;
      v2_r <= v1_r;
    end
  end

  // Multiply and accumulate; query elements past the received length read as zero.
  assign qmask = (i1_r < qlen_r) ? $signed(qdout) : '0;

  always_ff @(posedge clk) begin
    wi_r   <= idx_r;
    i1_r   <= idx_r;
    prod_r <= $signed(vdout) * qmask;
    if (cmd.mac_clr) begin
      acc_r <= '0;
    end else if (v2_r) begin
      acc_r <= acc_r + ACC_W'(prod_r);
    end
  end

  // Saturate the dot product to the score range.
  always_comb begin
    if ((&acc_r[ACC_W-1:SCORE_W-1]) || !(|acc_r[ACC_W-1:SCORE_W-1])) begin
      sat_s = acc_r[SCORE_W-1:0];
    end else if (acc_r[ACC_W-1]) begin
      sat_s = {1'b1, {(SCORE_W-1){1'b0}}};
    end else begin
      sat_s = {1'b0, {(SCORE_W-1){1'b1}}};
    end
  end

  // Sorted insertion: entries at or above the new score stay, the rest move down one.
  always_comb begin
    gx[0] = 1'b1;
    for (int j = 0; j < TOP_MAX; j++) begin
      ge[j]     = (j < int'(n_r)) && (best_s[j] >= sat_s);
      gx[j + 1] = ge[j];
      up_s[j]   = best_s[0];
      up_r[j]   = best_r[0];
    end
    for (int j = 1; j < TOP_MAX; j++) begin
      up_s[j] = best_s[j - 1];
      up_r[j] = best_r[j - 1];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.insert) begin
      for (int j = 0; j < TOP_MAX; j++) begin
        if (!ge[j]) begin
          if (gx[j]) begin
            best_s[j] <= sat_s;
            best_r[j] <= row_r[RW-1:0];
          end else begin
            best_s[j] <= up_s[j];
            best_r[j] <= up_r[j];
          end
        end
      end
    end
  end

  // Memories. Row elements at or above the active dimension are stored as zero.
  assign vwdata = ((wi_r < qlen_r) && (wi_r < dim)) ? qdout : '0;
  assign kraddr = cmd.krd_best ? best_r[j_r] : row_r[RW-1:0];

  vits_ram #(.WIDTH(VAL_W), .DEPTH(DIM_MAX)) u_qram (
    .clk   (clk),
    .we    (elem_take),
    .waddr (cnt_r[IW-1:0]),
    .wdata (in_value),
    .raddr (idx_r[IW-1:0]),
    .rdata (qdout)
  );

  vits_ram #(.WIDTH(VAL_W), .DEPTH(VDEPTH)) u_vram (
    .clk   (clk),
    .we    (wv_r),
    .waddr ({tgt_r, wi_r[IW-1:0]}),
    .wdata (vwdata),
    .raddr ({row_r[RW-1:0], idx_r[IW-1:0]}),
    .rdata (vdout)
  );

  vits_ram #(.WIDTH(KEY_W + 1), .DEPTH(ROW_COUNT)) u_kram (
    .clk   (clk),
    .we    (cmd.key_wr),
    .waddr (tgt_r),
    .wdata ({cmd.key_valid, key_r}),
    .raddr (kraddr),
    .rdata (kdout)
  );

  vits_ram #(.WIDTH(RW), .DEPTH(ROW_COUNT)) u_sram (
    .clk   (clk),
    .we    (cmd.push && (32'(fc_r) < ROW_COUNT)),
    .waddr (fc_r[RW-1:0]),
    .wdata (tgt_r),
    .raddr (RW'(fc_r - UW'(1))),
    .rdata (sdout)
  );

  // Result register; a new beat loads when the old one is gone or being taken.
  assign fire = cmd.emit && sts.out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      if (cmd.emit_hit) begin
        out_status_r <= RES_HIT;
        out_key_r    <= kdout[KEY_W-1:0];
        out_score_r  <= best_s[j_r];
        out_row_r    <= best_r[j_r];
        out_final_r  <= sts.em_last;
      end else begin
        out_status_r <= cmd.resp_code;
        out_key_r    <= cmd.resp_key ? key_r : '0;
        out_score_r  <= '0;
        out_row_r    <= cmd.resp_row ? tgt_r : '0;
        out_final_r  <= 1'b1;
      end
    end
  end

  assign out_valid     = out_valid_r;
  assign out_status    = out_status_r;
  assign out_hit_key   = out_key_r;
  assign out_score     = out_score_r;
  assign out_row       = ROW_OUT_W'(out_row_r);
  assign out_final_res = out_final_r;

  // Status for the controller.
  always_comb begin
    sts.op_add     = (op_r == OP_ADD);
    sts.row_end    = (row_r == used_r);
    sts.key_hit    = kdout[KEY_W] && (kdout[KEY_W-1:0] == key_r);
    sts.row_live   = kdout[KEY_W];
    sts.free_avail = (fc_r != '0);
    sts.new_avail  = (32'(used_r) < ROW_COUNT);
    sts.idx_last   = (idx_r == CW'(DIM_MAX - 1));
    sts.mac_last   = (idx_r == (dim - CW'(1)));
    sts.pipe_busy  = v1_r || v2_r;
    sts.k_zero     = (k_r == '0);
    sts.n_zero     = (n_r == '0);
    sts.em_last    = ((32'(j_r) + 1) == 32'(n_r));
    sts.out_free   = !out_valid_r || out_ready;
  end

endmodule

### src/vector_index_topk_search.sv
// Top level of the keyed vector table with dot-product top-k search.
//
// Usage: vectors arrive one element per beat on the in_ channel (valid/ready).
// Add (op 0) and search (op 2) beats fill a shared query buffer; the beat with
// in_last high ends the vector. Remove (op 1) is a single beat. cfg_wr_en with
// cfg_wr_data sets the elements per vector; the user must write it only while
// idle, as the block itself does not enforce this. Element beats are taken one
// per cycle. A remove or an add first scans the used rows for the key, reading
// and then checking each row; an add then writes DIM_MAX elements to the row
// store, one per cycle through the vector memory port. A search scores every
// live row with one multiply-accumulate per cycle, then emits the hits,
// highest score first, reading each hit's key before emitting it. Results
// leave through an output register on the out_ channel; a stalled receiver
// holds the block in its emit step, and in_ready stays low until the last
// result of the operation is loaded. After reset the table is empty, the
// dimension is 256, and the block is ready at once.
`timescale 1ns / 1ps
module vector_index_topk_search import vits_pkg::*; #(
  parameter int ROW_COUNT = 1024,
  parameter int DIM_MAX = 256,
  parameter int TOP_MAX = 16
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_wr_en,
  input  logic [DIM_CFG_W-1:0]       cfg_wr_data,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [1:0]                 in_op,
  input  logic [KEY_W-1:0]           in_key,
  input  logic signed [VAL_W-1:0]    in_value,
  input  logic                       in_last,
  input  logic [WANT_W-1:0]          in_want_count,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [2:0]                 out_status,
  output logic [KEY_W-1:0]           out_hit_key,
  output logic signed [SCORE_W-1:0]  out_score,
  output logic [ROW_OUT_W-1:0]       out_row,
  output logic                       out_final_res
);

  cmd_t cmd;
  sts_t sts;

  // Sequencer.
  vits_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_op    (in_op),
    .in_last  (in_last),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Storage and arithmetic.
  vits_dp #(
    .ROW_COUNT (ROW_COUNT),
    .DIM_MAX   (DIM_MAX),
    .TOP_MAX   (TOP_MAX)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .in_op         (in_op),
    .in_key        (in_key),
    .in_value      (in_value),
    .in_last       (in_last),
    .in_want_count (in_want_count),
    .cmd           (cmd),
    .sts           (sts),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_status    (out_status),
    .out_hit_key   (out_hit_key),
    .out_score     (out_score),
    .out_row       (out_row),
    .out_final_res (out_final_res)
  );

endmodule

### tb/vits_result_checker.sv
// Result checker for the vector index top-k search block: predicts and compares every result beat.
`timescale 1ns / 1ps
module vits_result_checker import vits_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_wr_en,
  input  logic [DIM_CFG_W-1:0]      cfg_wr_data,
  input  logic                      in_valid,
  input  logic                      in_ready,
  input  logic [1:0]                in_op,
  input  logic [KEY_W-1:0]          in_key,
  input  logic signed [VAL_W-1:0]   in_value,
  input  logic                      in_last,
  input  logic [WANT_W-1:0]         in_want_count,
  input  logic                      out_valid,
  input  logic                      out_ready,
  input  logic [2:0]                out_status,
  input  logic [KEY_W-1:0]          out_hit_key,
  input  logic signed [SCORE_W-1:0] out_score,
  input  logic [ROW_OUT_W-1:0]      out_row,
  input  logic                      out_final_res,
  output int                        mismatch_count,
  output int                        pending_results
);

  localparam int ROWS = 1024;
  localparam int DIMS = 256;
  localparam int TOPS = 16;

  typedef struct {
    logic [2:0]         status;
    logic [KEY_W-1:0]   hit_key;
    logic [SCORE_W-1:0] score;
    logic [ROW_OUT_W-1:0] row;
    logic               final_res;
  } table_result_t;

  // Shadow copy of the table and the element buffer.
  bit signed [VAL_W-1:0] row_elems [0:ROWS-1][0:DIMS-1];
  bit [KEY_W-1:0]        row_key   [0:ROWS-1];
  bit                    row_live  [0:ROWS-1];
  int                    freed_rows [0:ROWS-1];
  int                    freed_count;
  int                    rows_taken;
  bit signed [VAL_W-1:0] elem_buf  [0:DIMS-1];
  int                    elem_count;
  bit [DIM_CFG_W-1:0]    dim_setting;
  table_result_t         expected_results [$];

  initial begin
    mismatch_count = 0;
    pending_results = 0;
    for (int r = 0; r < ROWS; r++)
      for (int i = 0; i < DIMS; i++)
        row_elems[r][i] = '0;
  end

  // Elements per vector as the block applies them.
  function automatic int active_dim();
    if (dim_setting == 0) return 1;
    if (dim_setting > DIMS) return DIMS;
    return int'(dim_setting);
  endfunction

  function automatic int lookup_row(bit [KEY_W-1:0] key);
    for (int r = 0; r < rows_taken && r < ROWS; r++)
      if (row_live[r] && row_key[r] == key) return r;
    return -1;
  endfunction

  // Exact dot product, saturated to the score width.
  function automatic logic signed [SCORE_W-1:0] dot_score(int r, int d);
    longint acc;
    acc = 0;
    for (int i = 0; i < d; i++)
      acc += longint'(row_elems[r][i]) * longint'(elem_buf[i]);
    if (acc > 64'sd2147483647) return 32'sh7FFF_FFFF;
    if (acc < -64'sd2147483648) return 32'sh8000_0000;
    return acc[31:0];
  endfunction

  function automatic void push_result(res_t st, bit [KEY_W-1:0] key,
                                      logic [SCORE_W-1:0] sc, int r, bit fin);
    table_result_t res;
    res.status = st;
    res.hit_key = key;
    res.score = sc;
    res.row = r[ROW_OUT_W-1:0];
    res.final_res = fin;
    expected_results.insert(expected_results.size(), res);
  endfunction

  // Works out the results of one accepted input beat.
  task automatic predict_beat(op_t op, bit [KEY_W-1:0] key, bit signed [VAL_W-1:0] value,
                              bit last, int want);
    int d;
    int r;
    int k;
    int n;
    int j;
    logic signed [SCORE_W-1:0] s;
    logic signed [SCORE_W-1:0] top_scores [0:TOPS-1];
    int top_rows [0:TOPS-1];
    d = active_dim();
    if (op == OP_REMOVE) begin
      r = lookup_row(key);
      if (r < 0) begin
        push_result(RES_NOT_FOUND, key, '0, 0, 1'b1);
      end else begin
        row_live[r] = 1'b0;
        for (int i = 0; i < DIMS; i++) row_elems[r][i] = '0;
        if (freed_count < ROWS) begin
          freed_rows[freed_count] = r;
          freed_count++;
        end
        push_result(RES_REMOVED, key, '0, r, 1'b1);
      end
      return;
    end
    if (op == OP_NONE) return;

    // Element beat: store into the shared buffer while room remains.
    if (elem_count < d) begin
      elem_buf[elem_count] = value;
      elem_count++;
    end
    if (!last) return;
    for (int i = elem_count; i < DIMS; i++) elem_buf[i] = '0;
    elem_count = 0;

    if (op == OP_ADD) begin
      r = lookup_row(key);
      if (r < 0) begin
        if (freed_count > 0) begin
          freed_count--;
          r = freed_rows[freed_count] % ROWS;
        end else if (rows_taken < ROWS) begin
          r = rows_taken;
          rows_taken++;
        end else begin
          push_result(RES_FULL, key, '0, 0, 1'b1);
          return;
        end
        row_key[r] = key;
        row_live[r] = 1'b1;
      end
      for (int i = 0; i < DIMS; i++) row_elems[r][i] = (i < d) ? elem_buf[i] : '0;
      push_result(RES_ADDED, key, '0, r, 1'b1);
      return;
    end

    // Search: insertion into a sorted list, ties keep the lower row first.
    k = (want > TOPS) ? TOPS : want;
    n = 0;
    if (k > 0) begin
      for (r = 0; r < rows_taken && r < ROWS; r++) begin
        if (!row_live[r]) continue;
        s = dot_score(r, d);
        if (n == k && s <= top_scores[n-1]) continue;
        if (n < k) begin
          j = n;
          n++;
        end else begin
          j = n - 1;
        end
        while (j > 0 && s > top_scores[j-1]) begin
          top_scores[j] = top_scores[j-1];
          top_rows[j] = top_rows[j-1];
          j--;
        end
        top_scores[j] = s;
        top_rows[j] = r;
      end
    end
    if (n == 0) begin
      push_result(RES_NO_HITS, '0, '0, 0, 1'b1);
      return;
    end
    for (j = 0; j < n; j++)
      push_result(RES_HIT, row_key[top_rows[j]], top_scores[j], top_rows[j], j + 1 == n);
  endtask

  // One line per mismatch; printing stops after a while but counting goes on.
  task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want_val);
    mismatch_count++;
    if (mismatch_count <= 30)
      $display("%0t mismatch on %s: got %h, expected %h", $realtime, field, got, want_val);
  endtask

  // Watch both channels and the register port at every rising edge.
  always @(posedge clk) begin
    table_result_t exp_res;
    if (!rst_n) begin
      for (int r = 0; r < ROWS; r++) row_live[r] = 1'b0;
      for (int i = 0; i < DIMS; i++) elem_buf[i] = '0;
      freed_count = 0;
      rows_taken = 0;
      elem_count = 0;
      dim_setting = DIM_CFG_RESET;
      expected_results.delete();
    end else begin
      if (cfg_wr_en) dim_setting = cfg_wr_data;
      if (in_valid && in_ready)
        predict_beat(op_t'(in_op), in_key, in_value, in_last, int'(in_want_count));
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected beat, status", 64'(out_status), '0);
        end else begin
          exp_res = expected_results.pop_front();
          if (out_status !== exp_res.status)
            report_mismatch("status", 64'(out_status), 64'(exp_res.status));
          if (out_hit_key !== exp_res.hit_key)
            report_mismatch("hit_key", out_hit_key, exp_res.hit_key);
          if (out_score !== exp_res.score)
            report_mismatch("score", 64'(out_score), 64'(exp_res.score));
          if (out_row !== exp_res.row)
            report_mismatch("row", 64'(out_row), 64'(exp_res.row));
          if (out_final_res !== exp_res.final_res)
            report_mismatch("final_res", 64'(out_final_res), 64'(exp_res.final_res));
        end
      end
    end
    pending_results = expected_results.size();
  end

endmodule

### tb/testbench.sv
// Top of the testbench: clock, reset, stimulus and verdict for the top-k search block.
`timescale 1ns / 1ps
module testbench;
  import vits_pkg::*;

  localparam int CYCLE_LIMIT = 8000000;
  localparam int SETTLE_CYCLES = 400;

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      cfg_wr_en = 1'b0;
  logic [DIM_CFG_W-1:0]      cfg_wr_data = '0;
  logic                      in_valid = 1'b0;
  logic                      in_ready;
  logic [1:0]                in_op = OP_NONE;
  logic [KEY_W-1:0]          in_key = '0;
  logic signed [VAL_W-1:0]   in_value = '0;
  logic                      in_last = 1'b0;
  logic [WANT_W-1:0]         in_want_count = '0;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  logic [2:0]                out_status;
  logic [KEY_W-1:0]          out_hit_key;
  logic signed [SCORE_W-1:0] out_score;
  logic [ROW_OUT_W-1:0]      out_row;
  logic                      out_final_res;

  int mismatch_count;
  int pending_results;
  int cycle_count = 0;
  int send_idle = 0;
  int recv_idle = 0;
  int phase_dim = 256;
  bit [KEY_W-1:0] key_pool [0:15];

  always #5 clk = ~clk;

  vector_index_topk_search dut (
    .clk, .rst_n, .cfg_wr_en, .cfg_wr_data,
    .in_valid, .in_ready, .in_op, .in_key, .in_value, .in_last, .in_want_count,
    .out_valid, .out_ready, .out_status, .out_hit_key, .out_score, .out_row,
    .out_final_res
  );

  vits_result_checker u_checker (
    .clk, .rst_n, .cfg_wr_en, .cfg_wr_data,
    .in_valid, .in_ready, .in_op, .in_key, .in_value, .in_last, .in_want_count,
    .out_valid, .out_ready, .out_status, .out_hit_key, .out_score, .out_row,
    .out_final_res, .mismatch_count, .pending_results
  );

  // Receiver stalls at random.
  always @(posedge clk) out_ready <= ($urandom_range(99) >= recv_idle);

  // Run-away guard.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Presents one beat and holds it until accepted, then maybe idles the sender.
  task automatic send_beat(op_t op, bit [KEY_W-1:0] key, bit signed [VAL_W-1:0] value,
                           bit last, bit [WANT_W-1:0] want);
    in_valid <= 1'b1;
    in_op <= op;
    in_key <= key;
    in_value <= value;
    in_last <= last;
    in_want_count <= want;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  // Lets the block drain before a register write or the verdict.
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_dim(bit [DIM_CFG_W-1:0] dim);
    wait_drained();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= dim;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
    phase_dim = (dim == 0) ? 1 : (dim > 256) ? 256 : int'(dim);
  endtask

  function automatic bit signed [VAL_W-1:0] pick_value();
    case ($urandom_range(7))
      0: return 16'sh8000;
      1: return 16'sh7FFF;
      default: return VAL_W'($urandom());
    endcase
  endfunction

  function automatic bit [KEY_W-1:0] fresh_key();
    return {$urandom(), $urandom()};
  endfunction

  // Streams one vector; every beat but the last carries elem_op.
  task automatic send_vector(op_t elem_op, op_t last_op, bit [KEY_W-1:0] key, int len,
                             bit [WANT_W-1:0] want);
    for (int i = 0; i < len - 1; i++)
      send_beat(elem_op, key, pick_value(), 1'b0, WANT_W'($urandom()));
    send_beat(last_op, key, pick_value(), 1'b1, want);
  endtask

  // Mostly short vectors, sometimes the full dimension or a little past it.
  function automatic int vector_len();
    if ($urandom_range(5) == 0) return phase_dim + $urandom_range(1);
    return $urandom_range(1, (phase_dim < 8) ? phase_dim + 1 : 8);
  endfunction

  // One random operation; returns the beats that count toward the item budget.
  task automatic random_operation(output int beats);
    int pick;
    int len;
    bit [WANT_W-1:0] want;
    pick = $urandom_range(99);
    beats = 0;
    if (pick < 45) begin
      len = vector_len();
      send_vector(OP_ADD, OP_ADD, key_pool[$urandom_range(15)], len, WANT_W'($urandom()));
      beats = len;
    end else if (pick < 60) begin
      send_beat(OP_REMOVE, ($urandom_range(4) == 0) ? fresh_key() : key_pool[$urandom_range(15)],
                VAL_W'($urandom()), 1'($urandom()), WANT_W'($urandom()));
      beats = 1;
    end else if (pick < 90) begin
      len = vector_len();
      case ($urandom_range(9))
        0: want = 0;
        1: want = WANT_W'($urandom_range(17, 31));
        default: want = WANT_W'($urandom_range(1, 16));
      endcase
      send_vector(($urandom_range(4) == 0) ? OP_ADD : OP_SEARCH, OP_SEARCH, fresh_key(), len,
                  want);
      beats = len;
    end else if (pick < 95) begin
      // Unknown operation: ignored by the block.
      send_beat(OP_NONE, fresh_key(), VAL_W'($urandom()), 1'($urandom()), WANT_W'($urandom()));
      beats = 1;
    end else begin
      // Broken sequence: a dangling element with no last.
      send_beat(($urandom_range(1) == 0) ? OP_ADD : OP_SEARCH, fresh_key(), pick_value(), 1'b0,
                WANT_W'($urandom()));
      beats = 1;
    end
  endtask

  task automatic random_phase(int items);
    int done;
    int beats;
    done = 0;
    while (done < items) begin
      random_operation(beats);
      done += beats;
    end
  endtask

  initial begin
    bit [DIM_CFG_W-1:0] phase_dims [0:5];
    bit [KEY_W-1:0] key_a;
    bit [KEY_W-1:0] key_b;
    phase_dims = '{9'd5, 9'd256, 9'd0, 9'd511, 9'd12, 9'd3};
    for (int i = 0; i < 16; i++) key_pool[i] = fresh_key();
    key_a = key_pool[0];
    key_b = key_pool[1];

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty table, saturation both ways, ties, removes, reuse, odd keys.
    send_beat(OP_SEARCH, '0, 16'sd100, 1'b1, 5'd3);
    for (int v = 0; v < 2; v++)
      for (int i = 0; i < 3; i++)
        send_beat(OP_ADD, v == 0 ? key_a : key_b, 16'sh8000, i == 2, '0);
    for (int i = 0; i < 3; i++) send_beat(OP_SEARCH, '0, 16'sh7FFF, i == 2, 5'd31);
    for (int i = 0; i < 3; i++) send_beat(OP_SEARCH, '0, 16'sh8000, i == 2, 5'd1);
    send_beat(OP_NONE, '1, 16'sh7FFF, 1'b1, 5'd31);
    send_beat(OP_SEARCH, '0, 16'sd0, 1'b1, 5'd0);
    send_beat(OP_REMOVE, key_a, '0, 1'b0, '0);
    send_beat(OP_REMOVE, key_a, '0, 1'b1, '0);
    send_beat(OP_ADD, key_pool[2], 16'sh7FFF, 1'b1, '0);
    send_beat(OP_ADD, '0, 16'sd5, 1'b0, '0);
    send_beat(OP_SEARCH, '0, 16'sd7, 1'b1, 5'd16);
    send_beat(OP_ADD, '1, 16'sh0000, 1'b1, '0);
    send_beat(OP_ADD, '0, 16'sh0001, 1'b1, '0);
    send_beat(OP_REMOVE, '1, '0, 1'b1, '0);
    send_beat(OP_REMOVE, '0, '0, 1'b1, '0);

    // Random phases across several dimension settings and idling patterns.
    for (int p = 0; p < 6; p++) begin
      if (p < 2) begin
        send_idle = 22;
        recv_idle = 75;
      end else if (p < 4) begin
        send_idle = 75;
        recv_idle = 22;
      end else begin
        send_idle = 0;
        recv_idle = 0;
      end
      write_dim(phase_dims[p]);
      random_phase(75);
    end

    wait_drained();
    if (mismatch_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

### sim.f
src/vits_pkg.sv
src/vits_ram.sv
src/vits_ctrl.sv
src/vits_dp.sv
src/vector_index_topk_search.sv
tb/vits_result_checker.sv
tb/testbench.sv
